// ===== sv/spq_pkg.sv =====
// Package for the sorted priority queue: operation and status codes, field widths
// and the control struct handed from the core to each storage cell.
// Has no dependencies; every other file imports it.
package spq_pkg;

   localparam int TICKET_W = 16;
   localparam int FILL_W   = 5;

   typedef enum logic {
      OP_INSERT  = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic ins;
      logic deq;
   } cell_ctrl_type;

endpackage

// ===== sv/spq_if.sv =====
// Request and response channel interfaces of the sorted priority queue.
// Depends on spq_pkg for the field widths.
interface spq_req_if import spq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                operation;
   logic [TICKET_W-1:0] ticket_number;
   logic                request_type;

   modport source (output valid, operation, ticket_number, request_type, input ready);
   modport sink (input valid, operation, ticket_number, request_type, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [TICKET_W-1:0] head_ticket;
   logic                head_type;
   logic [FILL_W-1:0]   fill_count;

   modport source (output valid, status, head_ticket, head_type, fill_count, input ready);
   modport sink (input valid, status, head_ticket, head_type, fill_count, output ready);
endinterface

// ===== sv/spq_cell.sv =====
// One storage cell of the sorted chain: holds a key and a request kind.
// Depends on spq_pkg for the control struct.
module spq_cell import spq_pkg::*; #(
   parameter int KEY_BITS = 16
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic                occupied,
   input  logic                is_tail,
   input  logic [KEY_BITS-1:0] new_key,
   input  logic                new_type,
   input  logic                left_gt,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic                left_type,
   input  logic [KEY_BITS-1:0] right_key,
   input  logic                right_type,
   output logic [KEY_BITS-1:0] key,
   output logic                kind,
   output logic                gt
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                type_ff, type_in;

   // A stored key larger than the new one moves one place towards the tail.
   assign gt = occupied && (key_ff > new_key);

   always_comb begin
      key_in  = key_ff;
      type_in = type_ff;
      if (ctrl.deq) begin
         key_in  = right_key;
         type_in = right_type;
      end else if (ctrl.ins) begin
         if (left_gt) begin
            key_in  = left_key;
            type_in = left_type;
         end else if (gt || is_tail) begin
            key_in  = new_key;
            type_in = new_type;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      type_ff <= type_in;
   end

   assign key  = key_ff;
   assign kind = type_ff;

endmodule

// ===== sv/sorted_priority_queue_core.sv =====
// Response: registered, so a request is answered in the cycle after it is accepted.
// One request per cycle while responses are taken; an insert or dequeue moves all cells at once.
// The response register frees for a new request in the cycle its response is taken.
// Reset (synchronous) empties the queue and clears the response valid; cell contents are kept.
// Depends on spq_pkg, spq_if and spq_cell.
module sorted_priority_queue_core import spq_pkg::*; #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [TICKET_W-1:0] head_ticket_ff, head_ticket_in;
   logic                head_type_ff, head_type_in;

   logic                accept, full, empty;
   cell_ctrl_type       ctrl;
   logic [31:0]         ticket_ext;
   logic [31:0]         head_ext;
   logic [31:0]         fill_ext;
   logic [KEY_BITS-1:0] new_key;

   logic [KEY_BITS-1:0] key_w [DEPTH];
   logic                type_w [DEPTH];
   logic                gt_w [DEPTH];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = (count_ff == CNT_W'(DEPTH));
   assign empty          = (count_ff == '0);

   assign ticket_ext = {16'b0, req_chan.ticket_number};
   assign new_key    = ticket_ext[KEY_BITS-1:0];

   assign ctrl.ins = accept && (req_chan.operation == OP_INSERT) && !full;
   assign ctrl.deq = accept && (req_chan.operation == OP_DEQUEUE) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0] l_key, r_key;
      logic                l_type, r_type, l_gt;

      if (i == 0) begin : g_head
         assign l_key  = '0;
         assign l_type = 1'b0;
         assign l_gt   = 1'b0;
      end else begin : g_mid
         assign l_key  = key_w[i-1];
         assign l_type = type_w[i-1];
         assign l_gt   = gt_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign r_key  = '0;
         assign r_type = 1'b0;
      end else begin : g_body
         assign r_key  = key_w[i+1];
         assign r_type = type_w[i+1];
      end

      spq_cell #(.KEY_BITS(KEY_BITS)) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (CNT_W'(i) < count_ff),
         .is_tail    (CNT_W'(i) == count_ff),
         .new_key    (new_key),
         .new_type   (req_chan.request_type),
         .left_gt    (l_gt),
         .left_key   (l_key),
         .left_type  (l_type),
         .right_key  (r_key),
         .right_type (r_type),
         .key        (key_w[i]),
         .kind       (type_w[i]),
         .gt         (gt_w[i])
      );
   end

   assign head_ext = 32'(key_w[0]);

   always_comb begin
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      status_in      = status_ff;
      head_ticket_in = head_ticket_ff;
      head_type_in   = head_type_ff;
      if (accept) begin
         rsp_valid_in   = 1'b1;
         head_ticket_in = '0;
         head_type_in   = 1'b0;
         if (req_chan.operation == OP_INSERT) begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_INSERTED;
               count_in  = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               status_in      = ST_DEQUEUED;
               count_in       = count_ff - 1'b1;
               head_ticket_in = head_ext[TICKET_W-1:0];
               head_type_in   = type_w[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff      <= status_in;
      head_ticket_ff <= head_ticket_in;
      head_type_ff   <= head_type_in;
   end

   assign fill_ext             = 32'(count_ff);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.head_ticket = head_ticket_ff;
   assign rsp_chan.head_type   = head_type_ff;
   assign rsp_chan.fill_count  = fill_ext[FILL_W-1:0];

endmodule

// ===== sv/spq_checker.sv =====
// Port-level checks for the sorted priority queue core, and the bind that attaches them.
// Depends on spq_pkg for the status codes and field widths.
module spq_checker import spq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [1:0]          rsp_status,
   input logic [TICKET_W-1:0] rsp_head_ticket,
   input logic                rsp_head_type,
   input logic [FILL_W-1:0]   rsp_fill_count
);

   localparam logic [31:0] DEPTH_EXT = 32'(DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("Response dropped or changed while stalled.");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("Accepted request gave no response in the next cycle.");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_fill_count == '0)
      else $error("Empty response with a non-zero fill count.");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_fill_count == DEPTH_EXT[FILL_W-1:0])
      else $error("Full response with a fill count other than the depth.");

   a_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DEQUEUED) |-> rsp_head_ticket == '0 && !rsp_head_type)
      else $error("Head fields set on a response that dequeued nothing.");

endmodule

bind sorted_priority_queue_core spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_head_ticket (rsp_chan.head_ticket),
   .rsp_head_type   (rsp_chan.head_type),
   .rsp_fill_count  (rsp_chan.fill_count)
);
